/* sv/est_pkg.sv */
// -----------------------------------------------------------------------------
// est_pkg
// Shared constants, types and arithmetic helpers of the Euler transform unit.
// -----------------------------------------------------------------------------
package est_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 16;

	// angle to 32-bit phase
	localparam int          PH_SHIFT     = 32 - ANGLE_BITS;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	// quarter-wave sine series, Q30
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [31:0] K1  = 32'd1686629713;
	localparam logic [31:0] K3  = 32'd693598668;
	localparam logic [31:0] K5  = 32'd85569306;
	localparam logic [31:0] K7  = 32'd5026995;
	localparam logic [31:0] K9  = 32'd172272;
	localparam logic [31:0] K11 = 32'd3864;

	localparam int          SINE_STEPS  = 7;
	localparam int          SINE_IDX_W  = 3;
	localparam logic [2:0]  SINE_SQUARE = 3'd0;
	localparam logic [2:0]  SINE_FINAL  = 3'd6;

	// reciprocal divider, four quotient bits per step
	localparam int DIV_RADIX = 4;
	localparam int DIV_W     = FRAC_BITS + 9;
	localparam int DIV_STEPS = (DIV_W + DIV_RADIX - 1) / DIV_RADIX;
	localparam int QUO_W     = DIV_STEPS * DIV_RADIX;
	localparam int MAG_W     = 17;

	localparam int FRONT_STEPS = (DIV_STEPS > SINE_STEPS) ? DIV_STEPS : SINE_STEPS;
	localparam int CNT_W       = $clog2(FRONT_STEPS + 1);

	// column datapath
	localparam int ROT_W        = 33;
	localparam int PROD_W       = 66;
	localparam int MODEL_SHIFT  = 38 - FRAC_BITS;
	localparam int NORMAL_SHIFT = 30;

	localparam logic [2:0] COL_MOVE    = 3'd3;
	localparam logic [2:0] NORMAL_BASE = 3'd4;
	localparam logic [2:0] COL_LAST    = 3'd6;
	localparam logic [1:0] IDX_MOVE    = 2'd3;
	localparam logic [1:0] IDX_LAST    = 2'd2;

	localparam logic MAT_MODEL  = 1'b0;
	localparam logic MAT_NORMAL = 1'b1;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_RUN,
		FR_DONE
	} fr_state_t;

	typedef enum logic [1:0] {
		KIND_MODEL,
		KIND_MOVE,
		KIND_NORMAL
	} col_kind_t;

	typedef logic signed [ROT_W-1:0] rot_t;

	// one transform, ready for column emission
	typedef struct packed {
		logic [2:0][2:0][ROT_W-1:0] rot;   // [column][row]
		logic [2:0][15:0]           scale;
		logic [2:0][31:0]           recip;
		logic [2:0][31:0]           move;
	} xform_t;

	function automatic logic [31:0] sine_coef(input logic [2:0] idx);
		logic [31:0] k;
		case (idx)
			3'd1:    k = K9;
			3'd2:    k = K7;
			3'd3:    k = K5;
			3'd4:    k = K3;
			3'd5:    k = K1;
			default: k = K11;
		endcase
		return k;
	endfunction

	// Q30 product, floor
	function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[61:30];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > PROD_W'(SAT_MAX))
			r = SAT_MAX;
		else if (v < PROD_W'(SAT_MIN))
			r = SAT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* sv/est_sine_lane.sv */
// -----------------------------------------------------------------------------
// est_sine_lane
// Iterative quarter-wave sine of one phase, one shared multiplier.
// -----------------------------------------------------------------------------
module est_sine_lane (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic                                 step,
	input  logic [est_pkg::SINE_IDX_W-1:0]       step_idx,
	input  logic [31:0]                          phase,
	output logic signed [31:0]                   value
);

	logic [30:0]        v_q;
	logic               neg_q;
	logic [30:0]        x2_q;
	logic [31:0]        t_q;
	logic signed [31:0] res_q;

	logic [30:0] mul_a;
	logic [31:0] mul_b;
	logic [62:0] prod;
	logic [32:0] sh;
	logic [30:0] clamp;
	logic [31:0] mag;

	always_comb begin
		mul_a = (step_idx == est_pkg::SINE_SQUARE || step_idx == est_pkg::SINE_FINAL)
			? v_q : x2_q;
		mul_b = (step_idx == est_pkg::SINE_SQUARE) ? {1'b0, v_q} : t_q;
		prod  = 63'(mul_a) * 63'(mul_b);
		sh    = prod[62:30];
		clamp = (sh > 33'(est_pkg::Q30_ONE)) ? est_pkg::Q30_ONE : sh[30:0];
		mag   = {1'b0, clamp};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			// fold the phase into the first quarter turn
			v_q   <= phase[30] ? (est_pkg::Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
			neg_q <= phase[31];
			t_q   <= est_pkg::K11;
		end else if (step) begin
			case (step_idx)
				est_pkg::SINE_SQUARE: x2_q <= prod[60:30];
				est_pkg::SINE_FINAL:  res_q <= neg_q ? -$signed(mag) : $signed(mag);
				default:              t_q <= est_pkg::sine_coef(step_idx) - sh[31:0];
			endcase
		end
	end

	assign value = res_q;

endmodule

/* sv/est_recip.sv */
// -----------------------------------------------------------------------------
// est_recip
// Saturating reciprocal of a Q8.8 scale, restoring division, radix-16 steps.
// -----------------------------------------------------------------------------
module est_recip (
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic signed [15:0] scale,
	output logic signed [31:0] recip
);

	logic [est_pkg::QUO_W-1:0] dvd_q;
	logic [est_pkg::QUO_W-1:0] quo_q;
	logic [est_pkg::MAG_W-1:0] rem_q;
	logic [est_pkg::MAG_W-1:0] div_q;
	logic                      neg_q;
	logic                      zero_q;

	logic [est_pkg::QUO_W-1:0] dvd_n;
	logic [est_pkg::QUO_W-1:0] quo_n;
	logic [est_pkg::MAG_W-1:0] rem_n;
	logic signed [est_pkg::MAG_W-1:0] sext;
	logic [est_pkg::MAG_W-1:0] mag;
	logic [63:0]               q64;

	always_comb begin
		sext  = {scale[15], scale};
		mag   = scale[15] ? est_pkg::MAG_W'(-sext) : est_pkg::MAG_W'(sext);
		dvd_n = dvd_q;
		quo_n = quo_q;
		rem_n = rem_q;
		for (int i = 0; i < est_pkg::DIV_RADIX; i++) begin
			rem_n = {rem_n[est_pkg::MAG_W-2:0], dvd_n[est_pkg::QUO_W-1]};
			dvd_n = dvd_n << 1;
			quo_n = quo_n << 1;
			if (rem_n >= div_q) begin
				rem_n    = rem_n - div_q;
				quo_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q  <= est_pkg::QUO_W'(1) << (est_pkg::FRAC_BITS + 8);
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= mag;
			neg_q  <= scale[15];
			zero_q <= (scale == 16'sd0);
		end else if (step) begin
			dvd_q <= dvd_n;
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	// saturate the signed quotient
	always_comb begin
		q64 = 64'(quo_q);
		if (zero_q)
			recip = est_pkg::SAT_MAX;
		else if (neg_q)
			recip = (q64 > 64'h8000_0000) ? est_pkg::SAT_MIN : -$signed(q64[31:0]);
		else
			recip = (q64 > 64'h7FFF_FFFF) ? est_pkg::SAT_MAX : $signed(q64[31:0]);
	end

endmodule

/* sv/est_front.sv */
// -----------------------------------------------------------------------------
// est_front
// Accept a transform, run sine lanes and dividers, build the rotation matrix.
// -----------------------------------------------------------------------------
module est_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [15:0]           angle_x,
	input  logic [15:0]           angle_y,
	input  logic [15:0]           angle_z,
	input  logic signed [15:0]    scale_x,
	input  logic signed [15:0]    scale_y,
	input  logic signed [15:0]    scale_z,
	input  logic signed [31:0]    move_x,
	input  logic signed [31:0]    move_y,
	input  logic signed [31:0]    move_z,
	output logic                  push,
	output est_pkg::xform_t       push_word,
	input  logic                  queue_full
);

	est_pkg::fr_state_t state_q, state_n;
	logic [est_pkg::CNT_W-1:0] cnt_q;
	logic accept, hand, rot_en, lane_step, div_step;

	logic [2:0][15:0] scale_q;
	logic [2:0][31:0] move_q;

	logic [2:0][31:0]         phase;
	logic signed [31:0]       sn [3];
	logic signed [31:0]       cs [3];
	logic signed [31:0]       rc [3];

	// rotation pipeline
	logic v_s1, v_s2;
	logic signed [31:0] a_s1, b_s1, d_s1, e_s1, f_s1, g_s1, h_s1, i_s1, j_s1, k_s1;
	logic signed [31:0] s2_s1, s3_s1;
	logic [2:0][15:0]   scale_s1;
	logic [2:0][31:0]   recip_s1;
	logic [2:0][31:0]   move_s1;
	est_pkg::xform_t    word_s2;

	assign phase[0] = 32'(angle_x) << est_pkg::PH_SHIFT;
	assign phase[1] = 32'(angle_y) << est_pkg::PH_SHIFT;
	assign phase[2] = 32'(angle_z) << est_pkg::PH_SHIFT;

	assign rot_en     = !v_s2 || !queue_full;
	assign hand       = (state_q == est_pkg::FR_DONE) && rot_en;
	assign item_ready = (state_q == est_pkg::FR_IDLE) || hand;
	assign accept     = item_valid && item_ready;
	assign lane_step  = (state_q == est_pkg::FR_RUN) && (cnt_q < est_pkg::CNT_W'(est_pkg::SINE_STEPS));
	assign div_step   = (state_q == est_pkg::FR_RUN) && (cnt_q < est_pkg::CNT_W'(est_pkg::DIV_STEPS));

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_lane
			est_sine_lane u_sin (
				.clk      (clk),
				.load     (accept),
				.step     (lane_step),
				.step_idx (cnt_q[est_pkg::SINE_IDX_W-1:0]),
				.phase    (phase[g]),
				.value    (sn[g])
			);
			est_sine_lane u_cos (
				.clk      (clk),
				.load     (accept),
				.step     (lane_step),
				.step_idx (cnt_q[est_pkg::SINE_IDX_W-1:0]),
				.phase    (phase[g] + est_pkg::QUARTER_TURN),
				.value    (cs[g])
			);
		end
	endgenerate

	est_recip u_rcp_x (.clk(clk), .load(accept), .step(div_step), .scale(scale_x), .recip(rc[0]));
	est_recip u_rcp_y (.clk(clk), .load(accept), .step(div_step), .scale(scale_y), .recip(rc[1]));
	est_recip u_rcp_z (.clk(clk), .load(accept), .step(div_step), .scale(scale_z), .recip(rc[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= est_pkg::FR_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (accept)
				cnt_q <= '0;
			else if (state_q == est_pkg::FR_RUN)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			est_pkg::FR_IDLE: if (accept) state_n = est_pkg::FR_RUN;
			est_pkg::FR_RUN: begin
				if (cnt_q == est_pkg::CNT_W'(est_pkg::FRONT_STEPS - 1))
					state_n = est_pkg::FR_DONE;
			end
			est_pkg::FR_DONE: begin
				if (accept)
					state_n = est_pkg::FR_RUN;
				else if (hand)
					state_n = est_pkg::FR_IDLE;
			end
			default: state_n = est_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scale_q <= {scale_z, scale_y, scale_x};
			move_q  <= {move_z, move_y, move_x};
		end
	end

	// y: s1 c1, x: s2 c2, z: s3 c3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (rot_en) begin
			v_s1 <= hand;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rot_en) begin
			a_s1 <= est_pkg::mul_q30(cs[1], cs[2]);
			b_s1 <= est_pkg::mul_q30(sn[1], sn[0]);
			d_s1 <= est_pkg::mul_q30(cs[0], sn[2]);
			e_s1 <= est_pkg::mul_q30(cs[1], sn[0]);
			f_s1 <= est_pkg::mul_q30(cs[2], sn[1]);
			g_s1 <= est_pkg::mul_q30(cs[1], sn[2]);
			h_s1 <= est_pkg::mul_q30(cs[0], cs[2]);
			i_s1 <= est_pkg::mul_q30(sn[1], sn[2]);
			j_s1 <= est_pkg::mul_q30(cs[0], sn[1]);
			k_s1 <= est_pkg::mul_q30(cs[1], cs[0]);
			s2_s1    <= sn[0];
			s3_s1    <= sn[2];
			scale_s1 <= scale_q;
			recip_s1 <= {rc[2], rc[1], rc[0]};
			move_s1  <= move_q;

			word_s2.rot[0][0] <= est_pkg::ROT_W'(a_s1) + est_pkg::ROT_W'(est_pkg::mul_q30(b_s1, s3_s1));
			word_s2.rot[0][1] <= est_pkg::ROT_W'(d_s1);
			word_s2.rot[0][2] <= est_pkg::ROT_W'(est_pkg::mul_q30(e_s1, s3_s1)) - est_pkg::ROT_W'(f_s1);
			word_s2.rot[1][0] <= est_pkg::ROT_W'(est_pkg::mul_q30(f_s1, s2_s1)) - est_pkg::ROT_W'(g_s1);
			word_s2.rot[1][1] <= est_pkg::ROT_W'(h_s1);
			word_s2.rot[1][2] <= est_pkg::ROT_W'(est_pkg::mul_q30(a_s1, s2_s1)) + est_pkg::ROT_W'(i_s1);
			word_s2.rot[2][0] <= est_pkg::ROT_W'(j_s1);
			word_s2.rot[2][1] <= -est_pkg::ROT_W'(s2_s1);
			word_s2.rot[2][2] <= est_pkg::ROT_W'(k_s1);
			word_s2.scale     <= scale_s1;
			word_s2.recip     <= recip_s1;
			word_s2.move      <= move_s1;
		end
	end

	assign push      = v_s2 && !queue_full;
	assign push_word = word_s2;

endmodule

/* sv/est_back.sv */
// -----------------------------------------------------------------------------
// est_back
// Emit the seven columns of one transform, one column per cycle while the receiver is ready.
// -----------------------------------------------------------------------------
module est_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                entry_valid,
	input  est_pkg::xform_t     entry,
	output logic                pop,
	output logic                column_valid,
	input  logic                column_ready,
	output logic                which_matrix,
	output logic [1:0]          column_index,
	output logic signed [31:0]  entry_first,
	output logic signed [31:0]  entry_second,
	output logic signed [31:0]  entry_third,
	output logic                final_column
);

	logic [2:0] col_q;
	logic       en;
	logic       is_move, is_norm;
	logic [1:0] cidx, sel;
	logic signed [est_pkg::ROT_W-1:0] mul_a;
	logic signed [est_pkg::PROD_W-1:0] prod [3];

	logic                               valid_s1;
	est_pkg::col_kind_t                 kind_s1;
	logic                               which_s1, final_s1;
	logic [1:0]                         idx_s1;
	logic signed [est_pkg::PROD_W-1:0]  prod_s1 [3];

	logic        out_valid_q;
	logic        which_q, final_q;
	logic [1:0]  idx_q;
	logic signed [31:0] e_q [3];

	assign en  = !out_valid_q || column_ready;
	assign pop = en && entry_valid && (col_q == est_pkg::COL_LAST);

	always_comb begin
		is_move = (col_q == est_pkg::COL_MOVE);
		is_norm = (col_q >= est_pkg::NORMAL_BASE);
		cidx    = is_norm ? 2'(col_q - est_pkg::NORMAL_BASE) : col_q[1:0];
		sel     = is_move ? 2'd0 : cidx;
		mul_a   = is_norm ? est_pkg::ROT_W'($signed(entry.recip[sel]))
			: est_pkg::ROT_W'($signed(entry.scale[sel]));
		for (int r = 0; r < 3; r++) begin
			if (is_move)
				prod[r] = est_pkg::PROD_W'($signed(entry.move[r]));
			else
				prod[r] = est_pkg::PROD_W'(mul_a) * est_pkg::PROD_W'($signed(entry.rot[sel][r]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= entry_valid;
			out_valid_q <= valid_s1;
			if (entry_valid)
				col_q <= (col_q == est_pkg::COL_LAST) ? 3'd0 : col_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= is_move ? est_pkg::KIND_MOVE : (is_norm ? est_pkg::KIND_NORMAL : est_pkg::KIND_MODEL);
			which_s1 <= is_norm ? est_pkg::MAT_NORMAL : est_pkg::MAT_MODEL;
			idx_s1   <= cidx;
			final_s1 <= (col_q == est_pkg::COL_LAST);
			for (int r = 0; r < 3; r++)
				prod_s1[r] <= prod[r];

			which_q <= which_s1;
			idx_q   <= idx_s1;
			final_q <= final_s1;
			for (int r = 0; r < 3; r++) begin
				case (kind_s1)
					est_pkg::KIND_MOVE:   e_q[r] <= prod_s1[r][31:0];
					est_pkg::KIND_NORMAL: e_q[r] <= est_pkg::sat32(prod_s1[r] >>> est_pkg::NORMAL_SHIFT);
					default:              e_q[r] <= est_pkg::sat32(prod_s1[r] >>> est_pkg::MODEL_SHIFT);
				endcase
			end
		end
	end

	assign column_valid = out_valid_q;
	assign which_matrix = which_q;
	assign column_index = idx_q;
	assign entry_first  = e_q[0];
	assign entry_second = e_q[1];
	assign entry_third  = e_q[2];
	assign final_column = final_q;

	a_final_is_last_normal: assert property (@(posedge clk) disable iff (!arst_n)
		column_valid && final_column |-> which_matrix == est_pkg::MAT_NORMAL
			&& column_index == est_pkg::IDX_LAST)
		else $error("final word is not the last normal column");

	a_normal_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		column_valid && which_matrix == est_pkg::MAT_NORMAL |-> column_index != est_pkg::IDX_MOVE)
		else $error("normal matrix has no translation column");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= est_pkg::COL_LAST)
		else $error("column counter out of range");

	a_pop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> col_q == 3'd0)
		else $error("entry dropped before all columns were sent");

endmodule

/* sv/euler_scale_translate_matrix_core.sv */
// -----------------------------------------------------------------------------
// euler_scale_translate_matrix_core
// Y-X-Z Euler transform to model and normal matrix columns, fixed point.
// -----------------------------------------------------------------------------
// Input channel (item_valid / item_ready): one word per transform carrying
// three binary angles, three Q8.8 scales and a Q16.16 translation.
// Output channel (column_valid / column_ready): seven words per transform,
// model columns 0..3 (column 3 is the translation), then normal columns 0..2;
// final_column marks the seventh word.
// The front sequencer takes a new transform only once the previous one has
// finished its steps and been handed on; six sine lanes each run 7 multiply
// steps on one multiplier and the three reciprocal dividers retire 4 quotient
// bits a step. The back emits one column per cycle while the receiver is ready.
// From the accepting edge to the first column word being offered, a transform
// passes the 7 sequencer steps, 2 rotation stages, the queue write and 2 column
// stages.
// A two-entry queue decouples front and back; when the receiver stalls the
// output register holds its word, the queue fills and then item_ready drops.
// Reset clears all control state; no memory needs clearing.
// -----------------------------------------------------------------------------
module euler_scale_translate_matrix_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [15:0]        angle_x,
	input  logic [15:0]        angle_y,
	input  logic [15:0]        angle_z,
	input  logic signed [15:0] scale_x,
	input  logic signed [15:0] scale_y,
	input  logic signed [15:0] scale_z,
	input  logic signed [31:0] move_x,
	input  logic signed [31:0] move_y,
	input  logic signed [31:0] move_z,
	output logic               column_valid,
	input  logic               column_ready,
	output logic               which_matrix,
	output logic [1:0]         column_index,
	output logic signed [31:0] entry_first,
	output logic signed [31:0] entry_second,
	output logic signed [31:0] entry_third,
	output logic               final_column
);

	logic            push, pop, full, nonempty;
	est_pkg::xform_t push_word;

	// two-entry queue between front and back
	est_pkg::xform_t q_mem [2];
	logic            wr_q, rd_q;
	logic [1:0]      count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);

	est_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.angle_x    (angle_x),
		.angle_y    (angle_y),
		.angle_z    (angle_z),
		.scale_x    (scale_x),
		.scale_y    (scale_y),
		.scale_z    (scale_z),
		.move_x     (move_x),
		.move_y     (move_y),
		.move_z     (move_z),
		.push       (push),
		.push_word  (push_word),
		.queue_full (full)
	);

	// hold write and read pointers; advance on push and pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_q] <= push_word;
	end

	est_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (nonempty),
		.entry        (q_mem[rd_q]),
		.pop          (pop),
		.column_valid (column_valid),
		.column_ready (column_ready),
		.which_matrix (which_matrix),
		.column_index (column_index),
		.entry_first  (entry_first),
		.entry_second (entry_second),
		.entry_third  (entry_third),
		.final_column (final_column)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue count overflow");

endmodule

/* sim/euler_column_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// euler_column_checker
// Watches both channels, predicts the seven column words of every transform
// and compares each emitted word with the oldest prediction.
// -----------------------------------------------------------------------------
module euler_column_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  logic [15:0]        angle_x,
	input  logic [15:0]        angle_y,
	input  logic [15:0]        angle_z,
	input  logic signed [15:0] scale_x,
	input  logic signed [15:0] scale_y,
	input  logic signed [15:0] scale_z,
	input  logic signed [31:0] move_x,
	input  logic signed [31:0] move_y,
	input  logic signed [31:0] move_z,
	input  logic               column_valid,
	input  logic               column_ready,
	input  logic               which_matrix,
	input  logic [1:0]         column_index,
	input  logic signed [31:0] entry_first,
	input  logic signed [31:0] entry_second,
	input  logic signed [31:0] entry_third,
	input  logic               final_column,
	output int                 mismatches,
	output int                 columns_due,
	output int                 columns_seen,
	output int                 transforms_seen
);

	localparam longint QONE  = 64'd1073741824;
	localparam longint C_K1  = 64'd1686629713;
	localparam longint C_K3  = 64'd693598668;
	localparam longint C_K5  = 64'd85569306;
	localparam longint C_K7  = 64'd5026995;
	localparam longint C_K9  = 64'd172272;
	localparam longint C_K11 = 64'd3864;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;

	typedef struct {
		logic        mat;
		logic [1:0]  idx;
		logic [31:0] e0, e1, e2;
		logic        last;
	} column_word_t;

	column_word_t columns_expected[$];

	function automatic longint clamp32(longint v);
		if (v > I32_MAX) return I32_MAX;
		if (v < I32_MIN) return I32_MIN;
		return v;
	endfunction

	function automatic longint q30_product(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	// quarter-wave Horner series, everything unsigned and truncated
	function automatic longint sine_of_phase(logic [31:0] ph);
		longint unsigned u, v, x2, t, r;
		u = {34'd0, ph[29:0]};
		v = ph[30] ? QONE - u : u;
		x2 = (v * v) >> 30;
		t = C_K11;
		t = C_K9 - ((x2 * t) >> 30);
		t = C_K7 - ((x2 * t) >> 30);
		t = C_K5 - ((x2 * t) >> 30);
		t = C_K3 - ((x2 * t) >> 30);
		t = C_K1 - ((x2 * t) >> 30);
		r = (v * t) >> 30;
		if (r > QONE) r = QONE;
		return ph[31] ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint inverse_scale(longint s);
		if (s == 0) return I32_MAX;
		return clamp32((64'sd1 <<< (est_pkg::FRAC_BITS + 8)) / s);
	endfunction

	task automatic predict_columns();
		logic [31:0] px, py, pz;
		longint s1, c1, s2, c2, s3, c3, inv;
		longint sc[3];
		longint rot[3][3];
		longint e[3];
		column_word_t w;
		px = {angle_x, 16'd0};
		py = {angle_y, 16'd0};
		pz = {angle_z, 16'd0};
		s2 = sine_of_phase(px); c2 = sine_of_phase(px + est_pkg::QUARTER_TURN);
		s1 = sine_of_phase(py); c1 = sine_of_phase(py + est_pkg::QUARTER_TURN);
		s3 = sine_of_phase(pz); c3 = sine_of_phase(pz + est_pkg::QUARTER_TURN);
		sc[0] = scale_x; sc[1] = scale_y; sc[2] = scale_z;
		rot[0][0] = q30_product(c1, c3) + q30_product(q30_product(s1, s2), s3);
		rot[0][1] = q30_product(c2, s3);
		rot[0][2] = q30_product(q30_product(c1, s2), s3) - q30_product(c3, s1);
		rot[1][0] = q30_product(q30_product(c3, s1), s2) - q30_product(c1, s3);
		rot[1][1] = q30_product(c2, c3);
		rot[1][2] = q30_product(q30_product(c1, c3), s2) + q30_product(s1, s3);
		rot[2][0] = q30_product(c2, s1);
		rot[2][1] = -s2;
		rot[2][2] = q30_product(c1, c2);
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++)
				e[r] = clamp32((sc[c] * rot[c][r]) >>> est_pkg::MODEL_SHIFT);
			w = '{est_pkg::MAT_MODEL, 2'(c), e[0][31:0], e[1][31:0], e[2][31:0], 1'b0};
			columns_expected.push_back(w);
		end
		w = '{est_pkg::MAT_MODEL, est_pkg::IDX_MOVE, move_x, move_y, move_z, 1'b0};
		columns_expected.push_back(w);
		for (int c = 0; c < 3; c++) begin
			inv = inverse_scale(sc[c]);
			for (int r = 0; r < 3; r++)
				e[r] = clamp32((inv * rot[c][r]) >>> est_pkg::NORMAL_SHIFT);
			w = '{est_pkg::MAT_NORMAL, 2'(c), e[0][31:0], e[1][31:0], e[2][31:0], c == 2};
			columns_expected.push_back(w);
		end
	endtask

	initial begin
		mismatches = 0;
		columns_seen = 0;
		transforms_seen = 0;
	end

	assign columns_due = columns_expected.size();

	always @(posedge clk) begin
		column_word_t w;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				predict_columns();
				transforms_seen++;
			end
			if (column_valid && column_ready) begin
				columns_seen++;
				if (columns_expected.size() == 0) begin
					mismatches++;
					$display("%0t: column word with nothing expected", $time);
				end else begin
					w = columns_expected.pop_front();
					if ({which_matrix, column_index, entry_first, entry_second, entry_third,
						final_column} !== {w.mat, w.idx, w.e0, w.e1, w.e2, w.last}) begin
						mismatches++;
						$display("%0t: mismatch exp mat=%0d col=%0d %h %h %h last=%0d",
							$time, w.mat, w.idx, w.e0, w.e1, w.e2, w.last);
						$display("%0t:          got mat=%0d col=%0d %h %h %h last=%0d",
							$time, which_matrix, column_index, entry_first, entry_second,
							entry_third, final_column);
					end
				end
			end
		end
	end

endmodule

/* sim/euler_scale_translate_matrix_core_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// euler_scale_translate_matrix_core_tb
// Drives transforms into the matrix core with random idling on both sides and
// lets the column checker compare every emitted column word.
// -----------------------------------------------------------------------------
module euler_scale_translate_matrix_core_tb;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic [15:0]        angle_x, angle_y, angle_z;
	logic signed [15:0] scale_x, scale_y, scale_z;
	logic signed [31:0] move_x, move_y, move_z;
	logic               column_valid;
	logic               column_ready;
	logic               which_matrix;
	logic [1:0]         column_index;
	logic signed [31:0] entry_first, entry_second, entry_third;
	logic               final_column;

	int mismatches, columns_due, columns_seen, transforms_seen;
	int zero_scales;

	// handshakes between the word sender and the column receiver
	bit quiet;        // no idling in the last part of the run
	bit hold_request; // ask the receiver for one long stall
	bit hold_done;

	euler_scale_translate_matrix_core dut (.*);

	euler_column_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Limit: generous fixed bound on the whole run
	initial begin
		#5ms;
		$display("timeout waiting for column words");
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		int n;
		column_ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				column_ready <= 1'b0;
				// hold long enough for the queue to fill and item_ready to drop
				repeat (299) @(negedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 9);
				column_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				column_ready <= 1'b1;
			end
		end
	end

	// Offer one word and hold it until accepted; valid stays high afterwards.
	task automatic send_transform(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
		logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
		logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
		@(negedge clk);
		item_valid <= 1'b1;
		angle_x <= ax; angle_y <= ay; angle_z <= az;
		scale_x <= sx; scale_y <= sy; scale_z <= sz;
		move_x <= mx; move_y <= my; move_z <= mz;
		if (sx == 0 || sy == 0 || sz == 0) zero_scales++;
		do @(posedge clk); while (!item_ready);
	endtask

	// Now and then, unless quiet, drop valid for a random burst between words.
	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 9);
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 5))
			0:       return 16'($urandom_range(0, 3) * 16384);
			1:       return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'sd256;
			2:       return -16'sd256;
			3:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			4:       return 16'($urandom_range(0, 1) ? 1 : -1);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_random(int count);
		repeat (count) begin
			send_transform(pick_angle(), pick_angle(), pick_angle(),
				pick_scale(), pick_scale(), pick_scale(),
				$urandom, $urandom, $urandom);
			sender_gap();
		end
	endtask

	initial begin
		item_valid = 1'b0;
		angle_x = '0; angle_y = '0; angle_z = '0;
		scale_x = '0; scale_y = '0; scale_z = '0;
		move_x = '0; move_y = '0; move_z = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		zero_scales = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: identity, quadrant corners, scale and move extremes
		send_transform(16'd0, 16'd0, 16'd0, 16'sd256, 16'sd256, 16'sd256, '0, '0, '0);
		send_transform(16'd16384, 16'd0, 16'd0, 16'sd256, 16'sd512, 16'sd128,
			32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
		send_transform(16'd0, 16'd16384, 16'd0, 16'sd256, 16'sd256, 16'sd256,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		send_transform(16'd0, 16'd0, 16'd16384, -16'sd256, 16'sd256, -16'sd256,
			32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
		send_transform(16'd32768, 16'd32768, 16'd32768, 16'h7FFF, 16'h8000, 16'h7FFF,
			'0, '0, '0);
		send_transform(16'd49152, 16'd49152, 16'd49152, 16'h8000, 16'h7FFF, 16'h8000,
			'1, '1, '1);
		send_transform(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd1, -16'sd1, 16'sd1,
			'0, '0, '0);
		// zero scale: the inverse saturates, normal columns clip by sign
		send_transform(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, '0, '0, '0);
		send_transform(16'd8192, 16'd24576, 16'd40960, 16'd0, 16'sd256, 16'd0,
			32'h1234_5678, 32'hEDCB_A987, 32'h5555_AAAA);
		send_transform(16'd16383, 16'd16385, 16'd32767, 16'd0, 16'h8000, 16'h7FFF,
			32'hAAAA_5555, '0, '1);
		send_transform(16'd12345, 16'd54321, 16'd777, -16'sd1, 16'd0, 16'sd3,
			'0, '1, '0);
		send_transform(16'd5461, 16'd10923, 16'd60075, 16'sd2, -16'sd2, 16'd0,
			'0, '0, '0);

		send_random(200);

		// long receiver hold-off while words keep coming
		hold_request = 1'b1;
		send_random(20);
		wait (hold_done);
		hold_request = 1'b0;

		// pause the sender until every column word has arrived
		@(negedge clk);
		item_valid <= 1'b0;
		wait (columns_due == 0);

		send_random(170);
		quiet = 1'b1;
		send_random(100);
		@(negedge clk);
		item_valid <= 1'b0;

		wait (columns_due == 0);
		repeat (30) @(posedge clk);
		$display("covered %0d transforms (%0d with a zero scale), %0d column words",
			transforms_seen, zero_scales, columns_seen);
		if (mismatches == 0 && columns_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
